>>> rtl/ogb_pkg.sv
// ----------------------------------------------------------------------------
// Occupancy grid binning package
// Shared sizes, register indexes, operation codes and the front-to-back word.
// ----------------------------------------------------------------------------
package ogb_pkg;

  localparam int MaxRows   = 64;
  localparam int MaxCols   = 64;
  localparam int CountBits = 16;
  localparam int RowBits   = $clog2(MaxRows);
  localparam int ColBits   = $clog2(MaxCols);
  localparam int AddrBits  = RowBits + ColBits;
  localparam int Depth     = MaxRows * MaxCols;
  localparam int DimBits   = 7;
  localparam int QuoBits   = 17;
  localparam int QDepth    = 4;
  localparam int QPtrBits  = $clog2(QDepth);
  localparam logic [CountBits-1:0] CountTop = {CountBits{1'b1}};

  typedef enum logic [2:0] {
    REG_X_MIN = 3'd0,
    REG_X_MAX = 3'd1,
    REG_Y_MIN = 3'd2,
    REG_Y_MAX = 3'd3,
    REG_CELL  = 3'd4,
    REG_ROWS  = 3'd5,
    REG_COLS  = 3'd6
  } reg_idx_t;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_QUERY  = 1'b1
  } func_t;

  typedef struct packed {
    logic                      in_bounds;
    logic                      query;
    logic [RowBits-1:0]        row;
    logic [ColBits-1:0]        col;
    logic signed [15:0]        centre_x;
    logic signed [15:0]        centre_y;
  } job_t;

  function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
    if (v > 34'sd32767) begin
      return 16'sh7fff;
    end else if (v < -34'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

endpackage

>>> rtl/ogb_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ogb_ram #(
  parameter int Width = 16,
  parameter int Depth = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/ogb_front.sv
// ----------------------------------------------------------------------------
// Occupancy grid front end
// Checks bounds, divides the offsets bit-serially and forms the cell centre.
// ----------------------------------------------------------------------------
module ogb_front
  import ogb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               func,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] x_min,
  input  logic signed [15:0] x_max,
  input  logic signed [15:0] y_min,
  input  logic signed [15:0] y_max,
  input  logic [14:0]        cell_size,
  input  logic [DimBits-1:0] rows_in_use,
  input  logic [DimBits-1:0] cols_in_use,
  output logic               job_valid,
  input  logic               job_ready,
  output job_t               job
);

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_CX, S_CY, S_CEN, S_OUT} state_t;

  state_t              state;
  logic                query;
  logic                inb;
  logic [QuoBits-1:0]  rem_x, rem_y, quo_x, quo_y;
  logic [4:0]          step;
  logic [14:0]         size;
  logic [DimBits-1:0]  nr, nc;
  logic [RowBits-1:0]  row_up;
  logic [ColBits-1:0]  col;
  logic [32:0]         prod;
  logic [QuoBits:0]    tx, ty;
  logic [DimBits-1:0]  nr_next, nc_next;
  logic [QuoBits-1:0]  rx_sh, ry_sh;
  logic [ColBits-1:0]  col_c;
  logic [RowBits-1:0]  row_c;

  always_comb begin
    nr_next = (rows_in_use == '0) ? DimBits'(1) :
              (rows_in_use > DimBits'(MaxRows)) ? DimBits'(MaxRows) : rows_in_use;
    nc_next = (cols_in_use == '0) ? DimBits'(1) :
              (cols_in_use > DimBits'(MaxCols)) ? DimBits'(MaxCols) : cols_in_use;
    rx_sh = {rem_x[QuoBits-2:0], quo_x[QuoBits-1]};
    ry_sh = {rem_y[QuoBits-2:0], quo_y[QuoBits-1]};
    tx = {1'b0, rx_sh} - {3'b0, size};
    ty = {1'b0, ry_sh} - {3'b0, size};
    col_c = (quo_x > QuoBits'(nc - 1'b1)) ? ColBits'(nc - 1'b1) : quo_x[ColBits-1:0];
    row_c = (quo_y > QuoBits'(nr - 1'b1)) ? RowBits'(nr - 1'b1) : quo_y[RowBits-1:0];
  end

  assign in_ready  = (state == S_IDLE);
  assign job_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            query <= func;
            size  <= (cell_size == '0) ? 15'd1 : cell_size;
            nr    <= nr_next;
            nc    <= nc_next;
            inb   <= !(pos_x < x_min || pos_x > x_max || pos_y < y_min || pos_y > y_max);
            quo_x <= QuoBits'({pos_x[15], pos_x} - {x_min[15], x_min});
            quo_y <= QuoBits'({pos_y[15], pos_y} - {y_min[15], y_min});
            rem_x <= '0;
            rem_y <= '0;
            step  <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (!tx[QuoBits]) begin
            rem_x <= tx[QuoBits-1:0];
          end else begin
            rem_x <= rx_sh;
          end
          if (!ty[QuoBits]) begin
            rem_y <= ty[QuoBits-1:0];
          end else begin
            rem_y <= ry_sh;
          end
          quo_x <= {quo_x[QuoBits-2:0], ~tx[QuoBits]};
          quo_y <= {quo_y[QuoBits-2:0], ~ty[QuoBits]};
          step  <= step + 5'd1;
          if (step == 5'(QuoBits - 1)) begin
            state <= S_CX;
          end
        end
        S_CX: begin
          col   <= col_c;
          row_up <= row_c;
          prod  <= 33'({col_c, 1'b1}) * 33'(size);
          state <= S_CY;
        end
        S_CY: begin
          job.centre_x <= sat16(34'(signed'(x_min)) + 34'(prod[32:1]));
          prod  <= 33'({row_up, 1'b1}) * 33'(size);
          state <= S_CEN;
          job.in_bounds <= inb;
          job.query <= query;
          job.col <= col;
          job.row <= RowBits'(nr - 1'b1) - row_up;
        end
        S_CEN: begin
          job.centre_y <= sat16(34'(signed'(y_min)) + 34'(prod[32:1]));
          state <= S_OUT;
        end
        S_OUT: begin
          if (job_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/ogb_back.sv
// ----------------------------------------------------------------------------
// Occupancy grid back end
// Reads and updates cell counts and the total, and drives the result word.
// ----------------------------------------------------------------------------
module ogb_back
  import ogb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        job_valid,
  output logic        job_ready,
  input  job_t        job,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [95:0] out_data
);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ, S_OUT} state_t;

  state_t                state;
  job_t                  cur;
  logic [AddrBits-1:0]   clr;
  logic [31:0]           total;
  logic                  we;
  logic [AddrBits-1:0]   waddr, raddr;
  logic [CountBits-1:0]  wdata, rdata, cnt_next, count_val;
  logic [CountBits+15:0] count_wide;
  logic [15:0]           count_out;
  logic [31:0]           total_next, total_out;
  logic                  ins;
  logic [95:0]           word;

  assign raddr = {job.row, job.col};
  assign ins = (cur.query == FUNC_INSERT);
  assign cnt_next = (rdata == CountTop) ? rdata : rdata + 1'b1;
  assign count_val = ins ? cnt_next : rdata;
  assign count_wide = {16'b0, count_val};
  assign count_out = (count_wide > (CountBits+16)'(16'hffff)) ? 16'hffff :
                     count_wide[15:0];
  assign total_next = (total == '1) ? total : total + 32'd1;
  assign total_out = ins ? total_next : total;
  assign we = (state == S_CLEAR) || (state == S_READ && cur.in_bounds && ins);
  assign waddr = (state == S_CLEAR) ? clr : {cur.row, cur.col};
  assign wdata = (state == S_CLEAR) ? '0 : cnt_next;
  assign job_ready = (state == S_IDLE);

  ogb_ram #(.Width(CountBits), .Depth(Depth)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  ogb_back_fix u_pack (
    .in_bounds(cur.in_bounds), .row(6'(cur.row)), .col(6'(cur.col)),
    .count(count_out), .fresh(ins && (cnt_next == CountBits'(1))),
    .centre_x(cur.centre_x), .centre_y(cur.centre_y), .total(total_out),
    .word(word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == AddrBits'(Depth - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (job_valid) begin
            cur   <= job;
            state <= S_READ;
          end
        end
        S_READ: begin
          out_data <= word;
          if (cur.in_bounds && ins) begin
            total <= total_next;
          end
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

>>> rtl/ogb_back_fix.sv
// ----------------------------------------------------------------------------
// Occupancy grid result packer
// Packs the result fields into the 96-bit result word, all zero when the
// point lay outside the area.
// ----------------------------------------------------------------------------
module ogb_back_fix (
  input  logic        in_bounds,
  input  logic [5:0]  row,
  input  logic [5:0]  col,
  input  logic [15:0] count,
  input  logic        fresh,
  input  logic [15:0] centre_x,
  input  logic [15:0] centre_y,
  input  logic [31:0] total,
  output logic [95:0] word
);

  assign word = in_bounds ?
                {2'b00, total, centre_y, centre_x, fresh, count, col, row, 1'b1} :
                '0;

endmodule

>>> rtl/occupancy_grid_binning_unit.sv
// ----------------------------------------------------------------------------
// Occupancy grid binning unit
// Bins points into a 2D grid of saturating counts and answers cell queries.
// ----------------------------------------------------------------------------
// The front end accepts a word, divides both offsets by the cell size
// bit-serially, forms the row, the column and the cell centre, and hands the
// word off into a four-entry queue; it takes no new word until the last one
// has been handed off. The back end reads the count RAM for each word, updates
// it with a registered result, and outputs the result. When the result side
// stalls, the queue holds four words and the front end a fifth before the
// input stops. After reset the count RAM is cleared, and no word is accepted
// during the clear. Configuration is to be written only while no word is in
// flight.
module occupancy_grid_binning_unit
  import ogb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // func, pos_x, pos_y
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // in_bounds, cell_row, cell_col, cell_count,
                                 // new_cell, centre_x, centre_y, total_points
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic signed [15:0] x_min, x_max, y_min, y_max;
  logic [14:0]        cell_size;
  logic [DimBits-1:0] rows_in_use, cols_in_use;
  logic               f_valid, f_ready, b_valid, b_ready;
  job_t               f_job, b_job;
  job_t               q [QDepth];
  logic [QPtrBits:0]  wp, rp;
  logic               s_tready_f, clr_phase;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_min <= '0;
      x_max <= 16'sh7fff;
      y_min <= '0;
      y_max <= 16'sh7fff;
      cell_size <= 15'd16;
      rows_in_use <= DimBits'(64);
      cols_in_use <= DimBits'(64);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_X_MIN: x_min <= cfg_data;
        REG_X_MAX: x_max <= cfg_data;
        REG_Y_MIN: y_min <= cfg_data;
        REG_Y_MAX: y_max <= cfg_data;
        REG_CELL:  cell_size <= cfg_data[14:0];
        REG_ROWS:  rows_in_use <= cfg_data[DimBits-1:0];
        REG_COLS:  cols_in_use <= cfg_data[DimBits-1:0];
        default: ;
      endcase
    end
  end

  ogb_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid && !clr_phase), .in_ready(s_tready_f),
    .func(s_tdata[0]), .pos_x(s_tdata[16:1]), .pos_y(s_tdata[32:17]),
    .x_min(x_min), .x_max(x_max), .y_min(y_min), .y_max(y_max),
    .cell_size(cell_size), .rows_in_use(rows_in_use), .cols_in_use(cols_in_use),
    .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_phase <= 1'b1;
    end else if (b_ready) begin
      clr_phase <= 1'b0;
    end
  end
  assign s_tready = s_tready_f && !clr_phase;

  assign f_ready = (wp - rp) != (QPtrBits+1)'(QDepth);
  assign b_valid = (wp != rp);
  assign b_job = q[rp[QPtrBits-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
    end else begin
      if (f_valid && f_ready) begin
        q[wp[QPtrBits-1:0]] <= f_job;
        wp <= wp + 1'b1;
      end
      if (b_valid && b_ready) begin
        rp <= rp + 1'b1;
      end
    end
  end

  ogb_back u_back (
    .clk(clk), .rst(rst),
    .job_valid(b_valid), .job_ready(b_ready), .job(b_job),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata)
  );

endmodule

>>> rtl/ogb_checker.sv
// ----------------------------------------------------------------------------
// Occupancy grid binning checker
// Port-level properties of the result stream and of s_tready after reset.
// ----------------------------------------------------------------------------
module ogb_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [95:0] m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word dropped or changed while stalled");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[95:1] == '0)
    else $error("out-of-area result carries nonzero fields");

  a_new: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[29] |-> m_tdata[28:13] == 16'd1 && m_tdata[93:62] != '0)
    else $error("new cell flag without a count of one");

  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid && !s_tready)
    else $error("handshake active right after reset");

endmodule

bind occupancy_grid_binning_unit ogb_checker u_ogb_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
